// File: hw/rtl/assert_macros.svh
// Assertion helpers; every use names its own label.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/bwf_pkg.sv
`timescale 1ns / 1ps
package bwf_pkg;

  localparam int FREQ_W = 20;
  localparam logic [19:0] BW_MAX = 20'hFFFFF;

  localparam logic [2:0] MODE_ERB    = 3'd0;
  localparam logic [2:0] MODE_CAT    = 3'd1;
  localparam logic [2:0] MODE_CUSTOM = 3'd2;
  localparam logic [2:0] MODE_GPIG   = 3'd3;
  localparam logic [2:0] MODE_NONLIN = 3'd4;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_SCALE = 3'd1;
  localparam logic [2:0] REG_SLOPE = 3'd2;
  localparam logic [2:0] REG_MIN   = 3'd3;
  localparam logic [2:0] REG_INVQ  = 3'd4;

  localparam logic [43:0] CAT_C0  = 44'd7751556975821;
  localparam logic [27:0] CAT_C1  = 28'd256839044;
  localparam logic [30:0] CAT_C2  = 31'd1873047085;
  localparam logic [29:0] CAT_C3  = 30'd663898319;
  localparam logic [43:0] GPIG_C0 = 44'd14238675579699;
  localparam logic [27:0] GPIG_C1 = 28'd237511691;
  localparam logic [30:0] GPIG_C2 = 31'd1465471319;
  localparam logic [29:0] GPIG_C3 = 30'd461353069;

  localparam logic [21:0] DIV10_M = 22'd3355444;

  function automatic logic [15:0] ln_tab(input logic [5:0] i);
    logic [15:0] r;
    case (i)
      6'd0: r = 16'd0;      6'd1: r = 16'd2017;   6'd2: r = 16'd3973;
      6'd3: r = 16'd5873;   6'd4: r = 16'd7719;   6'd5: r = 16'd9515;
      6'd6: r = 16'd11262;  6'd7: r = 16'd12965;  6'd8: r = 16'd14624;
      6'd9: r = 16'd16242;  6'd10: r = 16'd17821; 6'd11: r = 16'd19364;
      6'd12: r = 16'd20870; 6'd13: r = 16'd22343; 6'd14: r = 16'd23783;
      6'd15: r = 16'd25193; 6'd16: r = 16'd26573; 6'd17: r = 16'd27924;
      6'd18: r = 16'd29248; 6'd19: r = 16'd30546; 6'd20: r = 16'd31818;
      6'd21: r = 16'd33067; 6'd22: r = 16'd34292; 6'd23: r = 16'd35494;
      6'd24: r = 16'd36675; 6'd25: r = 16'd37835; 6'd26: r = 16'd38975;
      6'd27: r = 16'd40095; 6'd28: r = 16'd41196; 6'd29: r = 16'd42280;
      6'd30: r = 16'd43345; 6'd31: r = 16'd44394; 6'd32: r = 16'd45426;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/bwf_if.sv
`timescale 1ns / 1ps
interface bwf_freq_if;
  logic                          valid;
  logic                          ready;
  logic [bwf_pkg::FREQ_W-1:0]    frequency;
  modport source (output valid, output frequency, input ready);
  modport sink (input valid, input frequency, output ready);
endinterface

interface bwf_bw_if;
  logic                          valid;
  logic                          ready;
  logic [bwf_pkg::FREQ_W-1:0]    bandwidth;
  logic                          mode_error;
  logic                          saturated;
  modport source (output valid, output bandwidth, output mode_error, output saturated,
                  input ready);
  modport sink (input valid, input bandwidth, input mode_error, input saturated,
                output ready);
endinterface

// File: hw/rtl/bandwidth_from_frequency.sv
`timescale 1ns / 1ps
// Auditory filter bandwidth from centre frequency.
// freq channel: one Q16.4 Hz frequency per word, valid/ready.
// result channel: bandwidth (Q16.4 Hz), mode_error, saturated per word.
// APB port sets mode and coefficients; write only while the pipe is empty.
// Throughput: one word per cycle while not stalled; the pipe is five
// register stages (input products, second products and table, sums,
// final products, select and clip into the output register).
// Stall: when the output word is held, every stage holds; nothing is
// dropped or repeated, and freq.ready is low only while it is held.
// Reset (rst, synchronous): APB registers take defaults, all stage
// valids clear; the first word can enter the cycle after reset drops.
module bandwidth_from_frequency (
  input  logic                clk,
  input  logic                rst,
  bwf_freq_if.sink            freq,
  bwf_bw_if.source            result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bwf_pkg::*;
  `include "assert_macros.svh"

  logic [2:0]  mode;
  logic [23:0] erb_scale, erb_slope, inv_q;
  logic [19:0] min_bw;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_ERB;
      erb_scale <= 24'd101171;
      erb_slope <= 24'd73316;
      min_bw    <= 20'd395;
      inv_q     <= 24'd7078;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_MODE:  mode      <= pwdata[2:0];
        REG_SCALE: erb_scale <= pwdata[23:0];
        REG_SLOPE: erb_slope <= pwdata[23:0];
        REG_MIN:   min_bw    <= pwdata[19:0];
        REG_INVQ:  inv_q     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MODE:  prdata = {29'd0, mode};
      REG_SCALE: prdata = {8'd0, erb_scale};
      REG_SLOPE: prdata = {8'd0, erb_slope};
      REG_MIN:   prdata = {12'd0, min_bw};
      REG_INVQ:  prdata = {8'd0, inv_q};
      default:   prdata = 32'd0;
    endcase
  end

  logic        gpig;
  logic [43:0] c0;
  logic [27:0] c1;
  logic [30:0] c2;
  logic [29:0] c3;
  assign gpig = (mode == MODE_GPIG);
  assign c0 = gpig ? GPIG_C0 : CAT_C0;
  assign c1 = gpig ? GPIG_C1 : CAT_C1;
  assign c2 = gpig ? GPIG_C2 : CAT_C2;
  assign c3 = gpig ? GPIG_C3 : CAT_C3;

  logic adv;
  assign adv = !result.valid || result.ready;
  assign freq.ready = adv;

  // stage 1
  logic        v1;
  logic [19:0] x1;
  logic [44:0] ta1;
  logic [44:0] cu1;
  logic [39:0] x2_1;
  logic [47:0] t1_1;
  logic [4:0]  p1;
  logic [18:0] fr1;
  logic [42:0] yq1;
  logic [4:0]  lead;
  logic [19:0] xn;

  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 20; i++) begin
      if (freq.frequency[i]) lead = 5'(i);
    end
    xn = freq.frequency << (5'd19 - lead);
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= freq.valid;
    if (adv) begin
      x1   <= freq.frequency;
      ta1  <= 45'(erb_slope * freq.frequency) + 45'd268435456;
      cu1  <= 45'(freq.frequency * inv_q) + 45'd32768;
      x2_1 <= freq.frequency * freq.frequency;
      t1_1 <= c1 * freq.frequency;
      p1   <= lead;
      fr1  <= xn[18:0];
      yq1  <= (21'(freq.frequency) + 21'd5) * DIV10_M;
    end
  end

  // stage 2
  logic        v2;
  logic        z2;
  logic [56:0] plo2;
  logic [36:0] phi2;
  logic [29:0] cust2;
  logic [47:0] x3_2;
  logic [46:0] t2_2;
  logic [47:0] t1_2;
  logic [15:0] lo2;
  logic [24:0] pr2;
  logic [4:0]  p2;
  logic [17:0] d10_2;
  logic [15:0] tab_a, tab_b;
  logic [58:0] c2x;

  assign tab_a = ln_tab({1'b0, fr1[18:14]});
  assign tab_b = ln_tab(6'({1'b0, fr1[18:14]}) + 6'd1);
  assign c2x   = c2 * x2_1[39:12];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      z2    <= (x1 == 20'd0);
      plo2  <= 57'(erb_scale * ta1[31:0]) + 57'h8_0000_0000;
      phi2  <= erb_scale * ta1[44:32];
      cust2 <= 30'(min_bw) + 30'(cu1[44:16]);
      x3_2  <= x2_1[39:12] * x1;
      t2_2  <= c2x[58:12];
      t1_2  <= t1_1;
      lo2   <= tab_a;
      pr2   <= 11'(tab_b - tab_a) * fr1[13:0];
      p2    <= p1;
      d10_2 <= yq1[42:25];
    end
  end

  // stage 3
  logic               v3;
  logic               z3;
  logic [33:0]        erb3;
  logic [29:0]        cust3;
  logic [49:0]        t3_3;
  logic [47:0]        t1_3;
  logic [46:0]        t2_3;
  logic signed [30:0] lnf3;
  logic [17:0]        d10_3;
  logic [37:0]        q;
  logic [57:0]        c3x;
  logic [16:0]        lnm;
  logic signed [5:0]  pm4;

  assign q   = 38'(phi2) + 38'(plo2[56:32]);
  assign c3x = c3 * x3_2[47:20];
  assign lnm = 17'(lo2) + 17'((26'(pr2) + 26'd8192) >> 14);
  assign pm4 = $signed({1'b0, p2}) - 6'sd4;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      z3    <= z2;
      erb3  <= q[37:4];
      cust3 <= cust2;
      t3_3  <= c3x[57:8];
      t1_3  <= t1_2;
      t2_3  <= t2_2;
      lnf3  <= $signed({6'd0, lnm, 8'd0}) + 31'(pm4) * 31'sd11629080;
      d10_3 <= d10_2;
    end
  end

  // stage 4
  logic               v4;
  logic               z4;
  logic [33:0]        erb4;
  logic [29:0]        cust4;
  logic signed [53:0] s4;
  logic signed [56:0] nv4;
  logic [17:0]        d10_4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      z4    <= z3;
      erb4  <= erb3;
      cust4 <= cust3;
      s4    <= $signed({10'd0, c0}) + $signed({6'd0, t1_3}) + $signed({4'd0, t3_3})
               - $signed({7'd0, t2_3});
      nv4   <= 57'(lnf3) * 57'sd18293719 - 57'sd1879065371869184;
      d10_4 <= d10_3;
    end
  end

  // stage 5: select, clip
  logic [53:0] sr;
  logic [56:0] vr;
  logic [33:0] sel;
  logic        err;

  assign sr = 54'(s4) + 54'h8000_0000;
  assign vr = 57'(nv4) + 57'h8_0000_0000;

  always_comb begin
    err = 1'b0;
    case (mode)
      MODE_ERB:    sel = erb4;
      MODE_CUSTOM: sel = 34'(cust4);
      MODE_CAT, MODE_GPIG:
        sel = (!s4[53] && s4 != 54'sd0) ? 34'(sr[53:32]) : 34'd0;
      MODE_NONLIN: begin
        if (z4) sel = 34'd0;
        else if (!nv4[56] && nv4 != 57'sd0) sel = 34'(vr[56:36]);
        else sel = 34'(d10_4);
      end
      default: begin
        sel = 34'd0;
        err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (adv) result.valid <= v4;
    if (adv) begin
      result.mode_error <= err;
      result.saturated  <= (sel > 34'(BW_MAX));
      result.bandwidth  <= (sel > 34'(BW_MAX)) ? BW_MAX : sel[19:0];
    end
  end

  `ASSERT_IMP(a_err_zero, result.valid && result.mode_error,
              result.bandwidth == 20'd0 && !result.saturated)
  `ASSERT_IMP(a_sat_max, result.valid && result.saturated, result.bandwidth == BW_MAX)
  `ASSERT_NEXT(a_accept_s1, freq.valid && freq.ready, v1)

endmodule
